// ===== rtl/ttc_pkg.sv =====
// Shared types, constants and cosine table builder for the TTC emergency brake block.
package ttc_pkg;

  localparam int MAX_BEAMS       = 4096;
  localparam int COS_TABLE_DEPTH = 1024;
  localparam int QUEUE_DEPTH     = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;
  localparam int COS_W      = 16;

  // Angles in 1/65536 rad
  localparam logic [18:0] TWO_PI_Q16     = 19'd411775;
  localparam logic [17:0] PI_Q16         = 18'd205887;
  localparam logic [16:0] HALF_PI_Q16    = 17'd102944;
  localparam logic [16:0] QUARTER_PI_Q16 = HALF_PI_Q16 / 2;
  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;

  localparam int PROD_W  = 28;
  localparam int ANG_W   = 29;
  localparam int QUO_W   = 11;
  localparam int REM_W   = 20;
  localparam int FOLD_W  = 18;
  localparam int RED_W   = 17;
  localparam int R2_W    = 18;
  localparam int RATE_W  = 32;
  localparam int RHS_W   = 47;

  // Reciprocal of 2*pi for the angle reduction
  localparam int          MOD_SHIFT      = 40;
  localparam logic [63:0] MOD_RECIP_FULL = (64'd1 << MOD_SHIFT) / 64'(TWO_PI_Q16);
  localparam int          MOD_RECIP_W    = $clog2(MOD_RECIP_FULL + 64'd1);
  localparam logic [MOD_RECIP_W-1:0] MOD_RECIP = MOD_RECIP_W'(MOD_RECIP_FULL);

  // Reciprocal of pi/2 for the table index
  localparam int          IDX_SHIFT      = 40;
  localparam logic [63:0] IDX_RECIP_FULL = (64'd1 << IDX_SHIFT) / 64'(HALF_PI_Q16);
  localparam int          IDX_RECIP_W    = $clog2(IDX_RECIP_FULL + 64'd1);
  localparam logic [IDX_RECIP_W-1:0] IDX_RECIP = IDX_RECIP_W'(IDX_RECIP_FULL);

  // range * 1000 * 2^15
  localparam logic [25:0] LHS_SCALE = 26'd32768000;

  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                             64'd90, 64'd132, 64'd182, 64'd240};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TTC_THRESHOLD = 3'd0,
    REG_MIN_RATE      = 3'd1,
    REG_FOV_FIRST     = 3'd2,
    REG_FOV_END       = 3'd3,
    REG_BEAM0_ANGLE   = 3'd4,
    REG_ANGLE_STEP    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic        [15:0] ttc_threshold_ms;
    logic        [14:0] min_range_rate;
    logic        [11:0] fov_first_beam;
    logic        [12:0] fov_end_beam;
    logic signed [18:0] beam0_angle;
    logic        [15:0] angle_step;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    ttc_threshold_ms: 16'd700,
    min_range_rate:   15'd0,
    fov_first_beam:   12'd0,
    fov_end_beam:     13'd0,
    beam0_angle:      -19'sd205887,
    angle_step:       16'd286
  };

  typedef enum logic {
    ITEM_SPEED = 1'b0,
    ITEM_BEAM  = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t         kind;
    logic signed [15:0] speed;
    logic        [11:0] beam;
    logic        [15:0] range;
    logic               in_window;
    logic               opens_scan;
    logic               last_beam;
  } work_item_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_ANGLE,
    B_ABS,
    B_MODQ,
    B_MODR,
    B_FOLD1,
    B_FOLD2,
    B_IDXN,
    B_IDXQ,
    B_IDXR,
    B_IDXC,
    B_RATE,
    B_PROD,
    B_DONE
  } back_state_t;

  // Q15 cosine of a Q30 angle, Taylor series to the x^16 term
  function automatic logic [COS_W-1:0] cos_entry(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    logic [63:0] rounded;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (int n = 0; n < 8; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if (n % 2 == 1) begin
        sum = sum + longint'(term);
      end else begin
        sum = sum - longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    rounded = (64'(sum) + 64'd16384) >> 15;
    return rounded[COS_W-1:0];
  endfunction

endpackage

// ===== rtl/ttc_cos_rom.sv =====
// Quarter-wave cosine ROM, Q15 magnitudes, registered read.
module ttc_cos_rom #(
  parameter int COS_TABLE_DEPTH = ttc_pkg::COS_TABLE_DEPTH
) (
  input  logic                                 clk,
  input  logic [$clog2(COS_TABLE_DEPTH+1)-1:0] addr,
  output logic [ttc_pkg::COS_W-1:0]            data
);

  logic [ttc_pkg::COS_W-1:0] rom_v [COS_TABLE_DEPTH+1];
  logic [ttc_pkg::COS_W-1:0] data_r;

  for (genvar k = 0; k <= COS_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] XK =
      (ttc_pkg::HALF_PI_Q30 * 64'(k)) / 64'(COS_TABLE_DEPTH);
    localparam logic [ttc_pkg::COS_W-1:0] VK = ttc_pkg::cos_entry(XK);
    assign rom_v[k] = VK;
  end

  always_ff @(posedge clk) begin
    data_r <= rom_v[addr];
  end

  assign data = data_r;

endmodule

// ===== rtl/ttc_front.sv =====
// Front end: accepts input transactions and classifies them against the beam window.
module ttc_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic signed [15:0]  in_speed_mm_s,
  input  logic        [11:0]  in_beam_index,
  input  logic        [15:0]  in_range_mm,
  input  logic                in_range_valid,
  input  ttc_pkg::cfg_t       cfg,
  input  logic                q_full,
  output logic                q_push,
  output ttc_pkg::work_item_t q_item
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.kind       = ttc_pkg::item_kind_t'(in_func);
    q_item.speed      = in_speed_mm_s;
    q_item.beam       = in_beam_index;
    q_item.range      = in_range_mm;
    q_item.in_window  = in_range_valid
                        && (in_beam_index >= cfg.fov_first_beam)
                        && (13'(in_beam_index) < cfg.fov_end_beam)
                        && (32'(in_beam_index) < 32'(ttc_pkg::MAX_BEAMS));
    q_item.opens_scan = (in_beam_index == cfg.fov_first_beam);
    q_item.last_beam  = ((13'(in_beam_index) + 13'd1) == cfg.fov_end_beam);
  end

endmodule

// ===== rtl/ttc_fifo.sv =====
// Short queue of classified items between front and back end.
module ttc_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ttc_pkg::work_item_t push_item,
  output logic                full,
  input  logic                pop,
  output ttc_pkg::work_item_t head,
  output logic                empty
);

  localparam int QD = ttc_pkg::QUEUE_DEPTH;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(QD + 1);

  ttc_pkg::work_item_t mem_r [QD];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(QD));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QD - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QD - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/ttc_back.sv =====
// Back end: speed store, beam angle reduction, cosine lookup and TTC test.
module ttc_back #(
  parameter int COS_TABLE_DEPTH = ttc_pkg::COS_TABLE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ttc_pkg::cfg_t       cfg,
  input  logic                q_empty,
  input  ttc_pkg::work_item_t q_head,
  output logic                q_pop,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                out_stop_flag,
  output logic                out_brake_event
);

  localparam int AW = $clog2(COS_TABLE_DEPTH + 1);
  localparam logic [63:0] N_MAX =
    64'(ttc_pkg::HALF_PI_Q16) * 64'(COS_TABLE_DEPTH) + 64'(ttc_pkg::QUARTER_PI_Q16);
  localparam int NW     = $clog2(N_MAX + 64'd1);
  localparam int IDX_PW = NW + ttc_pkg::IDX_RECIP_W + AW;
  localparam int MOD_PW = ttc_pkg::ANG_W + ttc_pkg::MOD_RECIP_W;

  ttc_pkg::back_state_t state_r, state_nxt;
  ttc_pkg::work_item_t  item_r, item_nxt;

  logic                               eval_r, eval_nxt;
  logic signed [15:0]                 speed_r, speed_nxt;
  logic                               stop_r, stop_nxt;
  logic                               halted_r, halted_nxt;
  logic [ttc_pkg::PROD_W-1:0]         prod_r, prod_nxt;
  logic [ttc_pkg::ANG_W-1:0]          ang_abs_r, ang_abs_nxt;
  logic [ttc_pkg::QUO_W-1:0]          quo_r, quo_nxt;
  logic [ttc_pkg::REM_W-1:0]          rem_r, rem_nxt;
  logic [ttc_pkg::FOLD_W-1:0]         fold_r, fold_nxt;
  logic [ttc_pkg::RED_W-1:0]          red_r, red_nxt;
  logic                               neg_r, neg_nxt;
  logic [NW-1:0]                      n_r, n_nxt;
  logic [AW-1:0]                      q2_r, q2_nxt;
  logic [ttc_pkg::R2_W-1:0]           r2_r, r2_nxt;
  logic signed [ttc_pkg::RATE_W-1:0]  rate_r, rate_nxt;
  logic                               rate_ok_r, rate_ok_nxt;
  logic [ttc_pkg::RHS_W-1:0]          rhs_r, rhs_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               out_stop_r, out_stop_nxt;
  logic                               out_event_r, out_event_nxt;

  logic                               head_eval;
  logic                               head_halted;
  logic                               done_fire;
  logic                               hit;
  logic [ttc_pkg::RHS_W-1:0]          lhs;
  logic [AW-1:0]                      rom_addr;
  logic [ttc_pkg::COS_W-1:0]          rom_data;
  logic [AW:0]                        idx_inc;

  logic signed [ttc_pkg::ANG_W:0]     ang_s;
  logic [MOD_PW-1:0]                  mod_prod;
  logic [ttc_pkg::ANG_W:0]            rem_full;
  logic [ttc_pkg::FOLD_W:0]           corr;
  logic [IDX_PW-1:0]                  idx_prod;
  logic [NW-1:0]                      r2_full;
  logic signed [ttc_pkg::COS_W:0]     cos_s;
  logic signed [ttc_pkg::RATE_W:0]    rate_full;

  ttc_cos_rom #(
    .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
  ) u_rom (
    .clk (clk),
    .addr(rom_addr),
    .data(rom_data)
  );

  assign head_halted = q_head.opens_scan ? 1'b0 : halted_r;
  assign head_eval   = (q_head.kind == ttc_pkg::ITEM_BEAM) && q_head.in_window && !head_halted;
  assign lhs         = ttc_pkg::RHS_W'(item_r.range) * ttc_pkg::RHS_W'(ttc_pkg::LHS_SCALE);
  assign hit         = eval_r && rate_ok_r && (lhs < rhs_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ttc_pkg::B_IDLE: begin
        if (!q_empty) begin
          state_nxt = head_eval ? ttc_pkg::B_ANGLE : ttc_pkg::B_DONE;
        end
      end
      ttc_pkg::B_ANGLE: state_nxt = ttc_pkg::B_ABS;
      ttc_pkg::B_ABS:   state_nxt = ttc_pkg::B_MODQ;
      ttc_pkg::B_MODQ:  state_nxt = ttc_pkg::B_MODR;
      ttc_pkg::B_MODR:  state_nxt = ttc_pkg::B_FOLD1;
      ttc_pkg::B_FOLD1: state_nxt = ttc_pkg::B_FOLD2;
      ttc_pkg::B_FOLD2: state_nxt = ttc_pkg::B_IDXN;
      ttc_pkg::B_IDXN:  state_nxt = ttc_pkg::B_IDXQ;
      ttc_pkg::B_IDXQ:  state_nxt = ttc_pkg::B_IDXR;
      ttc_pkg::B_IDXR:  state_nxt = ttc_pkg::B_IDXC;
      ttc_pkg::B_IDXC:  state_nxt = ttc_pkg::B_RATE;
      ttc_pkg::B_RATE:  state_nxt = ttc_pkg::B_PROD;
      ttc_pkg::B_PROD:  state_nxt = ttc_pkg::B_DONE;
      ttc_pkg::B_DONE: begin
        if (done_fire) begin
          state_nxt = ttc_pkg::B_IDLE;
        end
      end
      default: state_nxt = ttc_pkg::B_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop     = 1'b0;
    done_fire = 1'b0;
    case (state_r)
      ttc_pkg::B_IDLE: q_pop     = !q_empty;
      ttc_pkg::B_DONE: done_fire = !out_valid_r || out_ready;
      default: begin
        q_pop     = 1'b0;
        done_fire = 1'b0;
      end
    endcase
  end

  // Table index with rounding correction, capped at the last entry
  always_comb begin
    idx_inc  = (AW+1)'(q2_r) + ((r2_r >= ttc_pkg::R2_W'(ttc_pkg::HALF_PI_Q16)) ?
                                 (AW+1)'(1) : (AW+1)'(0));
    rom_addr = (idx_inc > (AW+1)'(COS_TABLE_DEPTH)) ? AW'(COS_TABLE_DEPTH) : idx_inc[AW-1:0];
  end

  // Datapath
  always_comb begin
    item_nxt      = item_r;
    eval_nxt      = eval_r;
    speed_nxt     = speed_r;
    stop_nxt      = stop_r;
    halted_nxt    = halted_r;
    prod_nxt      = prod_r;
    ang_abs_nxt   = ang_abs_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    fold_nxt      = fold_r;
    red_nxt       = red_r;
    neg_nxt       = neg_r;
    n_nxt         = n_r;
    q2_nxt        = q2_r;
    r2_nxt        = r2_r;
    rate_nxt      = rate_r;
    rate_ok_nxt   = rate_ok_r;
    rhs_nxt       = rhs_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_stop_nxt  = out_stop_r;
    out_event_nxt = out_event_r;

    ang_s     = (ttc_pkg::ANG_W+1)'(cfg.beam0_angle)
              + (ttc_pkg::ANG_W+1)'($signed({1'b0, prod_r}));
    mod_prod  = MOD_PW'(ang_abs_r) * MOD_PW'(ttc_pkg::MOD_RECIP);
    rem_full  = (ttc_pkg::ANG_W+1)'(ang_abs_r)
              - (ttc_pkg::ANG_W+1)'(quo_r) * (ttc_pkg::ANG_W+1)'(ttc_pkg::TWO_PI_Q16);
    corr      = (rem_r >= ttc_pkg::REM_W'(ttc_pkg::TWO_PI_Q16)) ?
                (ttc_pkg::FOLD_W+1)'(rem_r - ttc_pkg::REM_W'(ttc_pkg::TWO_PI_Q16)) :
                (ttc_pkg::FOLD_W+1)'(rem_r);
    idx_prod  = IDX_PW'(n_r) * IDX_PW'(ttc_pkg::IDX_RECIP);
    r2_full   = n_r - NW'(q2_r) * NW'(ttc_pkg::HALF_PI_Q16);
    cos_s     = neg_r ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
    rate_full = (ttc_pkg::RATE_W+1)'(speed_r) * (ttc_pkg::RATE_W+1)'(cos_s);

    case (state_r)
      ttc_pkg::B_IDLE: begin
        if (!q_empty) begin
          item_nxt = q_head;
          eval_nxt = head_eval;
          if (q_head.kind == ttc_pkg::ITEM_SPEED) begin
            speed_nxt = q_head.speed;
          end else begin
            halted_nxt = head_halted;
          end
        end
      end
      ttc_pkg::B_ANGLE: begin
        prod_nxt = ttc_pkg::PROD_W'(item_r.beam) * ttc_pkg::PROD_W'(cfg.angle_step);
      end
      ttc_pkg::B_ABS: begin
        ang_abs_nxt = ang_s[ttc_pkg::ANG_W] ? ttc_pkg::ANG_W'(-ang_s) : ttc_pkg::ANG_W'(ang_s);
      end
      ttc_pkg::B_MODQ: begin
        quo_nxt = mod_prod[ttc_pkg::MOD_SHIFT +: ttc_pkg::QUO_W];
      end
      ttc_pkg::B_MODR: begin
        rem_nxt = rem_full[ttc_pkg::REM_W-1:0];
      end
      ttc_pkg::B_FOLD1: begin
        fold_nxt = (corr > (ttc_pkg::FOLD_W+1)'(ttc_pkg::PI_Q16)) ?
                   ttc_pkg::FOLD_W'((ttc_pkg::FOLD_W+1)'(ttc_pkg::TWO_PI_Q16) - corr) :
                   ttc_pkg::FOLD_W'(corr);
      end
      ttc_pkg::B_FOLD2: begin
        if (fold_r > ttc_pkg::FOLD_W'(ttc_pkg::HALF_PI_Q16)) begin
          red_nxt = ttc_pkg::RED_W'(ttc_pkg::PI_Q16 - fold_r);
          neg_nxt = 1'b1;
        end else begin
          red_nxt = ttc_pkg::RED_W'(fold_r);
          neg_nxt = 1'b0;
        end
      end
      ttc_pkg::B_IDXN: begin
        n_nxt = NW'(red_r) * NW'(COS_TABLE_DEPTH) + NW'(ttc_pkg::QUARTER_PI_Q16);
      end
      ttc_pkg::B_IDXQ: begin
        q2_nxt = idx_prod[ttc_pkg::IDX_SHIFT +: AW];
      end
      ttc_pkg::B_IDXR: begin
        r2_nxt = r2_full[ttc_pkg::R2_W-1:0];
      end
      ttc_pkg::B_RATE: begin
        rate_nxt = rate_full[ttc_pkg::RATE_W-1:0];
      end
      ttc_pkg::B_PROD: begin
        rate_ok_nxt = rate_r > $signed({2'b00, cfg.min_range_rate, 15'd0});
        rhs_nxt     = ttc_pkg::RHS_W'(rate_r[ttc_pkg::RATE_W-2:0])
                    * ttc_pkg::RHS_W'(cfg.ttc_threshold_ms);
      end
      ttc_pkg::B_DONE: begin
        if (done_fire) begin
          if (hit) begin
            stop_nxt   = 1'b1;
            halted_nxt = 1'b1;
          end else if (eval_r && item_r.last_beam) begin
            stop_nxt = 1'b0;
          end
          out_valid_nxt = 1'b1;
          out_stop_nxt  = hit ? 1'b1 : ((eval_r && item_r.last_beam) ? 1'b0 : stop_r);
          out_event_nxt = hit;
        end
      end
      default: begin
        item_nxt = item_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttc_pkg::B_IDLE;
      speed_r     <= '0;
      stop_r      <= 1'b0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      speed_r     <= speed_nxt;
      stop_r      <= stop_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    eval_r      <= eval_nxt;
    prod_r      <= prod_nxt;
    ang_abs_r   <= ang_abs_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    fold_r      <= fold_nxt;
    red_r       <= red_nxt;
    neg_r       <= neg_nxt;
    n_r         <= n_nxt;
    q2_r        <= q2_nxt;
    r2_r        <= r2_nxt;
    rate_r      <= rate_nxt;
    rate_ok_r   <= rate_ok_nxt;
    rhs_r       <= rhs_nxt;
    out_stop_r  <= out_stop_nxt;
    out_event_r <= out_event_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_stop_flag   = out_stop_r;
  assign out_brake_event = out_event_r;

endmodule

// ===== rtl/ttc_emergency_brake_top.sv =====
// Top level of the time-to-collision emergency brake block.
// Usage:
//   in_*  : one transaction per speed update (in_func 0) or lidar beam sample (in_func 1).
//   out_* : exactly one result transaction per input transaction, in order:
//           out_stop_flag is the stop state after that input, out_brake_event pulses
//           on the sample that raised the stop.
//   cfg_* : register writes by index (0 threshold, 1 min rate, 2 first beam, 3 end beam,
//           4 angle of beam 0, 5 beam step); cfg_ready is always high. Write only while idle.
// Timing:
//   Speed updates and beams that are not evaluated go from B_IDLE straight to B_DONE in the
//   back end; an evaluated beam steps through the sequenced angle reduction, the two
//   reciprocal divisions, the cosine ROM read and the rate and threshold multiplies.
//   A two-entry queue between front and back end keeps in_ready high while the back
//   end works; in_ready drops only when the queue is full.
// Reset: synchronous, active low; registers return to their defaults, speed and stop
//   state clear and the queue empties.
// Stall: while out_ready is low the result is held and the back end waits with the next
//   result; the queue then fills and in_ready falls.
module ttc_emergency_brake_top #(
  parameter int COS_TABLE_DEPTH = ttc_pkg::COS_TABLE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_func,
  input  logic signed [15:0]               in_speed_mm_s,
  input  logic        [11:0]               in_beam_index,
  input  logic        [15:0]               in_range_mm,
  input  logic                             in_range_valid,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_stop_flag,
  output logic                             out_brake_event,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ttc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ttc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  ttc_pkg::cfg_t       cfg_r, cfg_nxt;
  ttc_pkg::work_item_t q_item;
  ttc_pkg::work_item_t q_head;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ttc_pkg::REG_TTC_THRESHOLD: cfg_nxt.ttc_threshold_ms = cfg_data[15:0];
        ttc_pkg::REG_MIN_RATE:      cfg_nxt.min_range_rate   = cfg_data[14:0];
        ttc_pkg::REG_FOV_FIRST:     cfg_nxt.fov_first_beam   = cfg_data[11:0];
        ttc_pkg::REG_FOV_END:       cfg_nxt.fov_end_beam     = cfg_data[12:0];
        ttc_pkg::REG_BEAM0_ANGLE:   cfg_nxt.beam0_angle      = $signed(cfg_data[18:0]);
        ttc_pkg::REG_ANGLE_STEP:    cfg_nxt.angle_step       = cfg_data[15:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ttc_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ttc_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_speed_mm_s (in_speed_mm_s),
    .in_beam_index (in_beam_index),
    .in_range_mm   (in_range_mm),
    .in_range_valid(in_range_valid),
    .cfg           (cfg_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_item)
  );

  ttc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(q_item),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  ttc_back #(
    .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_stop_flag  (out_stop_flag),
    .out_brake_event(out_brake_event)
  );

  a_event_sets_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_brake_event |-> out_stop_flag)
    else $error("brake event without stop flag");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue pushed while full");

endmodule
